>>> rtl/core/jna_pkg.sv
// Shared constants for the joystick normaliser and its averaging filter.
// No dependencies; the core takes these by scoped name.
`default_nettype none

package jna_pkg;

	// Widths of the command values and configuration data, the samples, the aux buttons and the register index.
	localparam int CMD_W = 16;
	localparam int SAMPLE_W = 10;
	localparam int AUX_W = 6;
	localparam int CFG_IDX_W = 4;

	// Normalisation: v = (SCALE_GAIN * (s - ref) + SCALE_OFFSET * ref) / ref.
	localparam int SCALE_GAIN = 2500;
	localparam int SCALE_OFFSET = 500;

	// History entries read as this value until first written.
	localparam int NEUTRAL_RESET = 500;

	// Shared divider: magnitude width, divisor width, bits retired per cycle, iteration count and counter width.
	localparam int DIV_W = 24;
	localparam int DVS_W = 10;
	localparam int DIV_RADIX = 4;
	localparam int DIV_ITER = DIV_W / DIV_RADIX;
	localparam int DIV_CNT_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_MODE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MID = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 4'd3;

	localparam logic MODE_ANALOG = 1'b0;
	localparam logic MODE_DIGITAL = 1'b1;

endpackage : jna_pkg

`default_nettype wire

>>> rtl/core/joystick_normalize_average.sv
// Joystick poll normaliser with a running-sum moving average.
// Depends on jna_pkg for constants and configuration register indexes.
`default_nettype none

// One poll enters per transaction on the input channel and gives exactly one command
// transaction on the output channel. In analog mode an accepted poll passes through the load,
// divide, post-processing, update and finish states before its result reaches the output
// register. A single shared restoring divider, retiring four quotient bits per cycle, runs
// four divisions in turn, each framed by a load and a post-processing state. The speed and
// direction normalisations against the reference come first, then the update state writes
// the history memory and updates the running sums, then the two window averages run, and the
// finish state loads the result. In digital mode an accepted poll goes straight to the finish
// state, which loads its result. While the output register is stalled the finished result
// waits and those stall cycles add to the poll. The input is stalled while a
// poll is in progress; a finished result waits in the output register and the next poll may
// be accepted meanwhile. The history lives in a WINDOW_LEN-entry memory with one valid flag
// per entry, so no clearing pass follows reset. Configuration is taken on any cycle but must
// only be written while the block is idle.
module joystick_normalize_average #(
	parameter int WINDOW_LEN = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,

	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [jna_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [jna_pkg::CMD_W-1:0]           cfg_data,

	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  [jna_pkg::SAMPLE_W-1:0]        speed_sample,
	input  wire  [jna_pkg::SAMPLE_W-1:0]        direction_sample,
	input  wire  [jna_pkg::SAMPLE_W-1:0]        reference_sample,
	input  wire                                 front_n,
	input  wire                                 back_n,
	input  wire                                 left_n,
	input  wire                                 right_n,
	input  wire                                 menu_n,
	input  wire                                 detect_n,
	input  wire  [jna_pkg::AUX_W-1:0]           aux_buttons_n,

	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic signed [jna_pkg::CMD_W-1:0]    delta_y,
	output logic signed [jna_pkg::CMD_W-1:0]    delta_x,
	output logic                                menu,
	output logic                                menu_valid,
	output logic [jna_pkg::AUX_W-1:0]           aux_buttons,
	output logic                                aux_valid
);

	localparam int CMD_W = jna_pkg::CMD_W;
	localparam int DIV_W = jna_pkg::DIV_W;
	localparam int DVS_W = jna_pkg::DVS_W;
	localparam int CNT_W = jna_pkg::DIV_CNT_W;
	localparam int OPND_W = DIV_W + 1;
	localparam int WPOS_W = $clog2(WINDOW_LEN);
	localparam int SUM_W = CMD_W + $clog2(WINDOW_LEN);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOAD   = 6'b000010,
		ST_DIV    = 6'b000100,
		ST_POST   = 6'b001000,
		ST_UPDATE = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		OP_NORM_SPEED = 2'd0,
		OP_NORM_DIR   = 2'd1,
		OP_AVG_SPEED  = 2'd2,
		OP_AVG_DIR    = 2'd3
	} op_t;

	// Configuration registers.
	logic                    input_mode_q;
	logic signed [CMD_W-1:0] out_min_q;
	logic signed [CMD_W-1:0] out_mid_q;
	logic signed [CMD_W-1:0] out_max_q;

	// Sequencer and captured poll.
	state_t                       state_q;
	op_t                          op_q;
	logic [CNT_W-1:0]             cnt_q;
	logic signed [OPND_W-1:0]     num_spd_q;
	logic signed [OPND_W-1:0]     num_dir_q;
	logic [jna_pkg::SAMPLE_W-1:0] ref_q;
	logic                         ref_zero_q;

	// Shared divider.
	logic [DVS_W-1:0] rem_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic             neg_q;

	// Filter state.
	logic [2*CMD_W-1:0]       hist_mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0]    hist_vld_q;
	logic [2*CMD_W-1:0]       hist_rd_q;
	logic                     hist_rd_vld_q;
	logic [WPOS_W-1:0]        wpos_q;
	logic signed [SUM_W-1:0]  sum_spd_q;
	logic signed [SUM_W-1:0]  sum_dir_q;
	logic signed [CMD_W-1:0]  vs_q;
	logic signed [CMD_W-1:0]  vd_q;

	// Result being assembled, and the output register.
	logic signed [CMD_W-1:0]      dy_q;
	logic signed [CMD_W-1:0]      dx_q;
	logic                         menu_q;
	logic                         menu_vld_q;
	logic [jna_pkg::AUX_W-1:0]    aux_q;
	logic                         aux_vld_q;
	logic                         out_valid_q;
	logic signed [CMD_W-1:0]      delta_y_q;
	logic signed [CMD_W-1:0]      delta_x_q;
	logic                         menu_out_q;
	logic                         menu_valid_q;
	logic [jna_pkg::AUX_W-1:0]    aux_buttons_q;
	logic                         aux_valid_q;

	logic                         in_acc;
	logic                         out_free;
	logic signed [OPND_W-1:0]     num_spd;
	logic signed [OPND_W-1:0]     num_dir;
	logic signed [OPND_W-1:0]     opnd;
	logic [DVS_W-1:0]             opnd_dvs;
	logic [OPND_W-1:0]            opnd_mag;
	logic [DVS_W-1:0]             rem_nxt;
	logic [DIV_W-1:0]             dvd_nxt;
	logic [DVS_W:0]               trial;
	logic signed [OPND_W-1:0]     quo;
	logic signed [OPND_W-1:0]     norm_raw;
	logic signed [OPND_W-1:0]     norm_lo;
	logic signed [OPND_W-1:0]     norm_cl;
	logic signed [CMD_W-1:0]      old_spd;
	logic signed [CMD_W-1:0]      old_dir;
	logic signed [CMD_W-1:0]      dig_dy;
	logic signed [CMD_W-1:0]      dig_dx;
	logic                         last_pos;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign delta_y = delta_y_q;
	assign delta_x = delta_x_q;
	assign menu = menu_out_q;
	assign menu_valid = menu_valid_q;
	assign aux_buttons = aux_buttons_q;
	assign aux_valid = aux_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_mode_q <= jna_pkg::MODE_ANALOG;
			out_min_q <= -16'sd2000;
			out_mid_q <= 16'sd500;
			out_max_q <= 16'sd3000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				jna_pkg::REG_INPUT_MODE: input_mode_q <= cfg_data[0];
				jna_pkg::REG_OUT_MIN: out_min_q <= cfg_data;
				jna_pkg::REG_OUT_MID: out_mid_q <= cfg_data;
				jna_pkg::REG_OUT_MAX: out_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The numerator wraps in modular arithmetic, which is exact for its signed range.
	assign num_spd = OPND_W'(speed_sample) * OPND_W'(jna_pkg::SCALE_GAIN)
		- OPND_W'(reference_sample) * OPND_W'(jna_pkg::SCALE_GAIN - jna_pkg::SCALE_OFFSET);
	assign num_dir = OPND_W'(direction_sample) * OPND_W'(jna_pkg::SCALE_GAIN)
		- OPND_W'(reference_sample) * OPND_W'(jna_pkg::SCALE_GAIN - jna_pkg::SCALE_OFFSET);

	// Digital switches: opposing pins together give the neutral value.
	always_comb begin
		if (!front_n && back_n) begin
			dig_dy = out_max_q;
		end else if (!back_n && front_n) begin
			dig_dy = out_min_q;
		end else begin
			dig_dy = out_mid_q;
		end
		if (!left_n && right_n) begin
			dig_dx = out_min_q;
		end else if (!right_n && left_n) begin
			dig_dx = out_max_q;
		end else begin
			dig_dx = out_mid_q;
		end
	end

	always_comb begin
		case (op_q)
			OP_NORM_SPEED: opnd = num_spd_q;
			OP_NORM_DIR: opnd = num_dir_q;
			OP_AVG_SPEED: opnd = OPND_W'(sum_spd_q);
			OP_AVG_DIR: opnd = OPND_W'(sum_dir_q);
			default: opnd = '0;
		endcase
		if (op_q == OP_NORM_SPEED || op_q == OP_NORM_DIR) begin
			opnd_dvs = DVS_W'(ref_q);
		end else begin
			opnd_dvs = DVS_W'(WINDOW_LEN);
		end
		opnd_mag = opnd[OPND_W-1] ? OPND_W'(-opnd) : OPND_W'(opnd);
	end

	// Restoring division, several quotient bits per cycle.
	always_comb begin
		rem_nxt = rem_q;
		dvd_nxt = dvd_q;
		trial = '0;
		for (int i = 0; i < jna_pkg::DIV_RADIX; i++) begin
			trial = {rem_nxt, dvd_nxt[DIV_W-1]};
			dvd_nxt = {dvd_nxt[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_nxt = DVS_W'(trial - {1'b0, dvs_q});
				dvd_nxt[0] = 1'b1;
			end else begin
				rem_nxt = trial[DVS_W-1:0];
			end
		end
	end

	// Quotient with truncation toward zero, then the clamp: ceiling applied last.
	always_comb begin
		quo = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
		norm_raw = ref_zero_q ? OPND_W'(out_mid_q) : quo;
		norm_lo = (norm_raw < OPND_W'(out_min_q)) ? OPND_W'(out_min_q) : norm_raw;
		norm_cl = (norm_lo > OPND_W'(out_max_q)) ? OPND_W'(out_max_q) : norm_lo;
	end

	assign old_spd = hist_rd_vld_q ? $signed(hist_rd_q[2*CMD_W-1:CMD_W])
		: CMD_W'(jna_pkg::NEUTRAL_RESET);
	assign old_dir = hist_rd_vld_q ? $signed(hist_rd_q[CMD_W-1:0])
		: CMD_W'(jna_pkg::NEUTRAL_RESET);
	assign last_pos = (wpos_q == WPOS_W'(WINDOW_LEN - 1));

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hist_rd_q <= hist_mem[wpos_q];
		end
		if (state_q == ST_UPDATE) begin
			hist_mem[wpos_q] <= {vs_q, vd_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_NORM_SPEED;
			cnt_q <= '0;
			hist_vld_q <= '0;
			hist_rd_vld_q <= 1'b0;
			wpos_q <= '0;
			sum_spd_q <= SUM_W'(jna_pkg::NEUTRAL_RESET * WINDOW_LEN);
			sum_dir_q <= SUM_W'(jna_pkg::NEUTRAL_RESET * WINDOW_LEN);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						num_spd_q <= num_spd;
						num_dir_q <= num_dir;
						ref_q <= reference_sample;
						ref_zero_q <= (reference_sample == '0);
						hist_rd_vld_q <= hist_vld_q[wpos_q];
						op_q <= OP_NORM_SPEED;
						if (input_mode_q == jna_pkg::MODE_DIGITAL) begin
							menu_vld_q <= 1'b1;
							if (detect_n) begin
								dy_q <= out_mid_q;
								dx_q <= out_mid_q;
								menu_q <= 1'b0;
								aux_q <= '0;
								aux_vld_q <= 1'b0;
							end else begin
								dy_q <= dig_dy;
								dx_q <= dig_dx;
								menu_q <= !menu_n;
								aux_q <= ~aux_buttons_n;
								aux_vld_q <= 1'b1;
							end
							state_q <= ST_FINISH;
						end else begin
							menu_q <= 1'b0;
							menu_vld_q <= 1'b0;
							aux_q <= ~aux_buttons_n;
							aux_vld_q <= 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					rem_q <= '0;
					dvd_q <= DIV_W'(opnd_mag);
					dvs_q <= opnd_dvs;
					neg_q <= opnd[OPND_W-1];
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_nxt;
					dvd_q <= dvd_nxt;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(jna_pkg::DIV_ITER - 1)) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					case (op_q)
						OP_NORM_SPEED: begin
							vs_q <= CMD_W'(norm_cl);
							op_q <= OP_NORM_DIR;
							state_q <= ST_LOAD;
						end
						OP_NORM_DIR: begin
							vd_q <= CMD_W'(norm_cl);
							state_q <= ST_UPDATE;
						end
						OP_AVG_SPEED: begin
							dy_q <= CMD_W'(quo);
							op_q <= OP_AVG_DIR;
							state_q <= ST_LOAD;
						end
						OP_AVG_DIR: begin
							dx_q <= CMD_W'(quo);
							state_q <= ST_FINISH;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_UPDATE: begin
					sum_spd_q <= sum_spd_q + SUM_W'(vs_q) - SUM_W'(old_spd);
					sum_dir_q <= sum_dir_q + SUM_W'(vd_q) - SUM_W'(old_dir);
					hist_vld_q[wpos_q] <= 1'b1;
					wpos_q <= last_pos ? '0 : wpos_q + 1'b1;
					op_q <= OP_AVG_SPEED;
					state_q <= ST_LOAD;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			delta_y_q <= dy_q;
			delta_x_q <= dx_q;
			menu_out_q <= menu_q;
			menu_valid_q <= menu_vld_q;
			aux_buttons_q <= aux_q;
			aux_valid_q <= aux_vld_q;
		end
	end

	// An accepted poll always starts work on the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_LOAD || state_q == ST_FINISH))
		else $error("accepted poll did not start");

	// A normalised speed value lies within the clamp bounds when they are ordered.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POST && op_q == OP_NORM_SPEED && out_min_q <= out_max_q)
		|=> (vs_q >= out_min_q && vs_q <= out_max_q))
		else $error("normalised speed outside clamp bounds");

	// Each history update moves the write position on, and it stays inside the window.
	a_wpos_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |=> (wpos_q != $past(wpos_q)
			&& wpos_q <= WPOS_W'(WINDOW_LEN - 1)))
		else $error("write position did not advance within the window");

	// The result is loaded into the output register only when it is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && state_q == ST_FINISH) |=> state_q == ST_FINISH)
		else $error("pending result overwritten");

endmodule : joystick_normalize_average

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for joystick_normalize_average: analog normalisation and averaging,
// digital switch decoding, register writes, random idling and output backpressure.
// Depends on jna_pkg and the joystick_normalize_average RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CMD_W = jna_pkg::CMD_W;
	localparam int SAMPLE_W = jna_pkg::SAMPLE_W;
	localparam int AUX_W = jna_pkg::AUX_W;
	localparam int CFG_IDX_W = jna_pkg::CFG_IDX_W;
	localparam int SCALE_GAIN = jna_pkg::SCALE_GAIN;
	localparam int SCALE_OFFSET = jna_pkg::SCALE_OFFSET;
	localparam int NEUTRAL_RESET = jna_pkg::NEUTRAL_RESET;
	localparam logic MODE_ANALOG = jna_pkg::MODE_ANALOG;
	localparam logic MODE_DIGITAL = jna_pkg::MODE_DIGITAL;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_MODE = jna_pkg::REG_INPUT_MODE;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = jna_pkg::REG_OUT_MIN;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MID = jna_pkg::REG_OUT_MID;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = jna_pkg::REG_OUT_MAX;

	localparam int WINDOW_LEN = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_POLLS = 145;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(REG_OUT_MAX + 1);
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED = '1;

	typedef struct {
		logic [SAMPLE_W-1:0] speed;
		logic [SAMPLE_W-1:0] direction;
		logic [SAMPLE_W-1:0] centre;
		logic front_n;
		logic back_n;
		logic left_n;
		logic right_n;
		logic menu_n;
		logic detect_n;
		logic [AUX_W-1:0] aux_n;
	} poll_t;

	typedef struct {
		logic signed [CMD_W-1:0] dy;
		logic signed [CMD_W-1:0] dx;
		logic menu;
		logic menu_valid;
		logic [AUX_W-1:0] aux;
		logic aux_valid;
	} command_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CMD_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [SAMPLE_W-1:0] speed_sample;
	logic [SAMPLE_W-1:0] direction_sample;
	logic [SAMPLE_W-1:0] reference_sample;
	logic front_n;
	logic back_n;
	logic left_n;
	logic right_n;
	logic menu_n;
	logic detect_n;
	logic [AUX_W-1:0] aux_buttons_n;
	logic out_valid;
	logic out_stall;
	logic signed [CMD_W-1:0] delta_y;
	logic signed [CMD_W-1:0] delta_x;
	logic menu;
	logic menu_valid;
	logic [AUX_W-1:0] aux_buttons;
	logic aux_valid;

	// Predicted copy of the block's settings and averaging window.
	logic mode_setting;
	logic signed [CMD_W-1:0] floor_setting;
	logic signed [CMD_W-1:0] neutral_setting;
	logic signed [CMD_W-1:0] ceiling_setting;
	int speed_window [WINDOW_LEN];
	int direction_window [WINDOW_LEN];
	int speed_run_sum;
	int direction_run_sum;
	int window_slot;

	command_t pending_commands [$];
	command_t want;
	command_t got;

	int errors = 0;
	int polls_sent;
	int analog_polls;
	int digital_polls;
	int commands_checked = 0;
	int reg_writes;
	int cycle_count;
	int hold_request;
	bit idle_on;

	joystick_normalize_average dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.speed_sample(speed_sample),
		.direction_sample(direction_sample),
		.reference_sample(reference_sample),
		.front_n(front_n),
		.back_n(back_n),
		.left_n(left_n),
		.right_n(right_n),
		.menu_n(menu_n),
		.detect_n(detect_n),
		.aux_buttons_n(aux_buttons_n),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.delta_y(delta_y),
		.delta_x(delta_x),
		.menu(menu),
		.menu_valid(menu_valid),
		.aux_buttons(aux_buttons),
		.aux_valid(aux_valid)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic reset_predictor();
		mode_setting = MODE_ANALOG;
		floor_setting = -16'sd2000;
		neutral_setting = 16'sd500;
		ceiling_setting = 16'sd3000;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			speed_window[i] = NEUTRAL_RESET;
			direction_window[i] = NEUTRAL_RESET;
		end
		speed_run_sum = NEUTRAL_RESET * WINDOW_LEN;
		direction_run_sum = NEUTRAL_RESET * WINDOW_LEN;
		window_slot = 0;
	endtask

	task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CMD_W-1:0] data);
		case (idx)
			REG_INPUT_MODE: mode_setting = data[0];
			REG_OUT_MIN: floor_setting = data;
			REG_OUT_MID: neutral_setting = data;
			REG_OUT_MAX: ceiling_setting = data;
			default: ;
		endcase
	endtask

	// The ceiling is applied after the floor, so it wins when the bounds are inverted.
	function automatic int normalise_axis(int s, int centre);
		int v;
		if (centre == 0)
			v = neutral_setting;
		else
			v = (SCALE_GAIN * (s - centre) + SCALE_OFFSET * centre) / centre;
		if (v < floor_setting)
			v = floor_setting;
		if (v > ceiling_setting)
			v = ceiling_setting;
		return v;
	endfunction

	function automatic command_t predict_command(poll_t p);
		command_t c;
		int vs;
		int vd;
		logic front;
		logic back;
		logic left;
		logic right;
		front = !p.front_n;
		back = !p.back_n;
		left = !p.left_n;
		right = !p.right_n;
		c.menu = 1'b0;
		c.menu_valid = 1'b0;
		c.aux = ~p.aux_n;
		c.aux_valid = 1'b1;
		if (mode_setting == MODE_DIGITAL && p.detect_n) begin
			c.dy = neutral_setting;
			c.dx = neutral_setting;
			c.menu_valid = 1'b1;
			c.aux = '0;
			c.aux_valid = 1'b0;
		end else if (mode_setting == MODE_ANALOG) begin
			vs = normalise_axis(int'(p.speed), int'(p.centre));
			vd = normalise_axis(int'(p.direction), int'(p.centre));
			speed_run_sum = speed_run_sum - speed_window[window_slot] + vs;
			direction_run_sum = direction_run_sum - direction_window[window_slot] + vd;
			speed_window[window_slot] = vs;
			direction_window[window_slot] = vd;
			window_slot = (window_slot + 1) % WINDOW_LEN;
			c.dy = CMD_W'(speed_run_sum / WINDOW_LEN);
			c.dx = CMD_W'(direction_run_sum / WINDOW_LEN);
		end else begin
			if (front && !back)
				c.dy = ceiling_setting;
			else if (back && !front)
				c.dy = floor_setting;
			else
				c.dy = neutral_setting;
			if (left && !right)
				c.dx = floor_setting;
			else if (right && !left)
				c.dx = ceiling_setting;
			else
				c.dx = neutral_setting;
			c.menu = !p.menu_n;
			c.menu_valid = 1'b1;
		end
		return c;
	endfunction

	// pins = {front_n, back_n, left_n, right_n, menu_n, detect_n}
	function automatic poll_t make_poll(int s, int d, int c, logic [5:0] pins,
			logic [AUX_W-1:0] aux);
		poll_t p;
		p.speed = SAMPLE_W'(s);
		p.direction = SAMPLE_W'(d);
		p.centre = SAMPLE_W'(c);
		{p.front_n, p.back_n, p.left_n, p.right_n, p.menu_n, p.detect_n} = pins;
		p.aux_n = aux;
		return p;
	endfunction

	function automatic int pick_sample();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return (1 << SAMPLE_W) - 1;
			default: return $urandom_range(0, (1 << SAMPLE_W) - 1);
		endcase
	endfunction

	function automatic poll_t random_poll(logic mode);
		poll_t p;
		int c;
		case ($urandom_range(0, 9))
			0: c = 0;
			1: c = $urandom_range(1, 8);
			2, 3, 4: c = $urandom_range(0, (1 << SAMPLE_W) - 1);
			default: c = $urandom_range(384, 640);
		endcase
		p = make_poll(pick_sample(), pick_sample(), c, 6'($urandom), AUX_W'($urandom));
		// A digital stick is mostly present, so the switch decoding gets most of the polls.
		if (mode == MODE_DIGITAL)
			p.detect_n = ($urandom_range(0, 7) == 0);
		return p;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CMD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_poll(poll_t p);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		speed_sample <= p.speed;
		direction_sample <= p.direction;
		reference_sample <= p.centre;
		front_n <= p.front_n;
		back_n <= p.back_n;
		left_n <= p.left_n;
		right_n <= p.right_n;
		menu_n <= p.menu_n;
		detect_n <= p.detect_n;
		aux_buttons_n <= p.aux_n;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (mode_setting == MODE_ANALOG)
			analog_polls++;
		else
			digital_polls++;
		polls_sent++;
		pending_commands.push_back(predict_command(p));
		@(negedge clk);
	endtask

	// Every poll gives one command, so an empty queue means the block is idle.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_commands.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_settings(logic mode, logic signed [CMD_W-1:0] lo,
			logic signed [CMD_W-1:0] mid, logic signed [CMD_W-1:0] hi);
		logic [CMD_W-1:0] mode_word;
		mode_word = CMD_W'($urandom);
		mode_word[0] = mode;
		drain_results();
		write_reg(REG_INPUT_MODE, mode_word);
		write_reg(REG_OUT_MIN, lo);
		write_reg(REG_OUT_MID, mid);
		write_reg(REG_OUT_MAX, hi);
		if ($urandom_range(0, 1))
			write_reg(CFG_IDX_W'($urandom_range(int'(REG_FIRST_UNUSED), int'(REG_LAST_UNUSED))),
				CMD_W'($urandom));
	endtask

	task automatic compare_field(string name, logic signed [31:0] want_v,
			logic signed [31:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
		end
	endtask

	task automatic test_reset_defaults();
		send_poll(make_poll(512, 512, 512, 6'b111111, 6'h00));
		send_poll(make_poll(0, 1023, 1023, 6'b000000, 6'h3f));
		send_poll(make_poll(1023, 0, 1, 6'b111101, 6'h15));
		// Negative quotient that is not exact, and a value above the ceiling.
		send_poll(make_poll(100, 700, 300, 6'b101001, 6'h2a));
		// Zero reference gives the neutral value, then it is averaged like any other.
		send_poll(make_poll(777, 3, 0, 6'b010110, 6'h00));
		// The detect and menu pins are ignored in analog mode.
		send_poll(make_poll(0, 0, 0, 6'b111101, 6'h3f));
	endtask

	task automatic test_digital_switches();
		logic [AUX_W-1:0] aux;
		load_settings(MODE_DIGITAL, -16'sd32768, 16'sd7, 16'sd32767);
		write_reg(REG_FIRST_UNUSED, 16'h1234);
		write_reg(REG_LAST_UNUSED, 16'hffff);
		for (int i = 0; i < 16; i++) begin
			aux = (i == 0) ? '0 : (i == 15) ? '1 : AUX_W'($urandom);
			send_poll(make_poll($urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 1023), {4'(i), i[0], 1'b0}, aux));
		end
		// Absent stick: neutral commands and the aux buttons are skipped.
		send_poll(make_poll(1023, 1023, 1023, 6'b000001, 6'h00));
		send_poll(make_poll(0, 0, 0, 6'b111111, 6'h3f));
	endtask

	task automatic test_backpressure();
		load_settings(MODE_ANALOG, -16'sd2000, 16'sd500, 16'sd3000);
		idle_on = 1'b0;
		hold_request++;
		repeat (24) send_poll(random_poll(MODE_ANALOG));
		drain_results();
		idle_on = 1'b1;
	endtask

	task automatic test_random_phases();
		logic mode;
		logic signed [CMD_W-1:0] lo;
		logic signed [CMD_W-1:0] mid;
		logic signed [CMD_W-1:0] hi;
		for (int phase = 0; phase < 8; phase++) begin
			lo = CMD_W'($urandom);
			mid = CMD_W'($urandom);
			hi = CMD_W'($urandom);
			mode = 1'($urandom_range(0, 1));
			case (phase)
				0: {mode, lo, mid, hi} = {MODE_ANALOG, -16'sd2000, 16'sd500, 16'sd3000};
				1: {mode, lo, mid, hi} = {MODE_ANALOG, -16'sd32768, 16'sd0, 16'sd32767};
				2: {mode, lo, mid, hi} = {MODE_ANALOG, 16'sd3000, 16'sd500, -16'sd2000};
				3: {mode, lo, mid, hi} = {MODE_DIGITAL, -16'sd32768, 16'sd0, 16'sd32767};
				4: begin
					mode = MODE_ANALOG;
					lo = CMD_W'($urandom_range(0, 4000)) - 16'sd2000;
					mid = lo;
					hi = lo;
				end
				5: mode = MODE_DIGITAL;
				6: mode = MODE_ANALOG;
				default: ;
			endcase
			load_settings(mode, lo, mid, hi);
			// The closing phase runs with no idling on either side.
			idle_on = (phase != 7);
			repeat (PHASE_POLLS) send_poll(random_poll(mode));
		end
	endtask

	// Output side: random stall bursts, plus a long hold-off for each one requested.
	initial begin
		int burst_left;
		int hold_left;
		int holds_done;
		burst_left = 0;
		hold_left = 0;
		holds_done = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > holds_done) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (idle_on && burst_left > 0) begin
				out_stall <= 1'b1;
				burst_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				burst_left = $urandom_range(1, 17) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got.dy = delta_y;
			got.dx = delta_x;
			got.menu = menu;
			got.menu_valid = menu_valid;
			got.aux = aux_buttons;
			got.aux_valid = aux_valid;
			if (pending_commands.size() == 0) begin
				errors++;
				$display("%0t ns: command transaction with no poll waiting, delta_y %0d delta_x %0d",
					$time, got.dy, got.dx);
			end else begin
				want = pending_commands.pop_front();
				compare_field("delta_y", want.dy, got.dy);
				compare_field("delta_x", want.dx, got.dx);
				compare_field("menu", want.menu, got.menu);
				compare_field("menu_valid", want.menu_valid, got.menu_valid);
				compare_field("aux_buttons", want.aux, got.aux);
				compare_field("aux_valid", want.aux_valid, got.aux_valid);
				commands_checked++;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d commands outstanding.", cycle_count,
			pending_commands.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		polls_sent = 0;
		analog_polls = 0;
		digital_polls = 0;
		reg_writes = 0;
		hold_request = 0;
		idle_on = 1'b1;
		reset_predictor();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		speed_sample = '0;
		direction_sample = '0;
		reference_sample = '0;
		front_n = 1'b1;
		back_n = 1'b1;
		left_n = 1'b1;
		right_n = 1'b1;
		menu_n = 1'b1;
		detect_n = 1'b0;
		aux_buttons_n = '1;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_digital_switches();
		test_backpressure();
		test_random_phases();

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_commands.size() != 0)
			$display("%0t ns: %0d commands never arrived", $time, pending_commands.size());
		$display("Sent %0d polls (%0d analog, %0d digital) and checked %0d commands.",
			polls_sent, analog_polls, digital_polls, commands_checked);
		$display("Made %0d register writes over reset, full-range, inverted and collapsed bounds.",
			reg_writes);
		if (errors == 0 && pending_commands.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/jna_pkg.sv
rtl/core/joystick_normalize_average.sv
verif/tb.sv
